FILE: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int OWNER_W       = 8;
    localparam int SIZE_W        = 16;
    localparam int GRANULE_SHIFT = 6;
    localparam int NEED_W        = SIZE_W - GRANULE_SHIFT;
    localparam int OFFSET_W      = 15;
    localparam int ID_W          = 7;

    localparam logic [OWNER_W-1:0] FREE_OWNER = 8'hff;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_SET_SIZE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ID   = 2'd1;
    localparam logic [1:0] ST_NO_RUN   = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   entry_id;
        logic [SIZE_W-1:0] byte_size;
    } req_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] byte_offset;
    } rsp_word_t;

    // write strobes from the sequencer to the storage
    typedef struct packed {
        logic map_we;
        logic size_we;
    } store_ctl_t;

endpackage

FILE: rtl/ffba_store.sv
// Owner map and size table storage with the post-reset clearing pass.
`timescale 1ns / 1ps

module ffba_store #(
    parameter int NUM_BLOCKS = 512,
    parameter int NUM_IDS    = 96,
    localparam int AW        = $clog2(NUM_BLOCKS),
    localparam int IW        = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffba_pkg::store_ctl_t           ctl,
    input  logic [AW-1:0]                  map_rd_addr,
    input  logic [AW-1:0]                  map_wr_addr,
    input  logic [ffba_pkg::OWNER_W-1:0]   map_wr_data,
    input  logic [IW-1:0]                  size_rd_addr,
    input  logic [IW-1:0]                  size_wr_addr,
    input  logic [ffba_pkg::SIZE_W-1:0]    size_wr_data,
    output logic [ffba_pkg::OWNER_W-1:0]   map_rdata,
    output logic [ffba_pkg::SIZE_W-1:0]    size_rdata,
    output logic                           busy
);

    localparam int CLR_DEPTH = (NUM_BLOCKS > NUM_IDS) ? NUM_BLOCKS : NUM_IDS;
    localparam int CLW       = $clog2(CLR_DEPTH + 1);

    logic [ffba_pkg::OWNER_W-1:0] map_mem  [NUM_BLOCKS];
    logic [ffba_pkg::SIZE_W-1:0]  size_mem [NUM_IDS];

    logic                         clearing_reg;
    logic [CLW-1:0]               clr_idx_reg;

    logic                         m_we;
    logic [AW-1:0]                m_addr;
    logic [ffba_pkg::OWNER_W-1:0] m_data;
    logic                         s_we;
    logic [IW-1:0]                s_addr;
    logic [ffba_pkg::SIZE_W-1:0]  s_data;
    logic [ffba_pkg::OWNER_W-1:0] map_rdata_reg;
    logic [ffba_pkg::SIZE_W-1:0]  size_rdata_reg;

    // clearing pass owns the write ports until it finishes
    always_comb
    begin
        if (clearing_reg)
        begin
            m_we   = (clr_idx_reg < CLW'(NUM_BLOCKS));
            m_addr = clr_idx_reg[AW-1:0];
            m_data = ffba_pkg::FREE_OWNER;
            s_we   = (clr_idx_reg < CLW'(NUM_IDS));
            s_addr = clr_idx_reg[IW-1:0];
            s_data = '0;
        end
        else
        begin
            m_we   = ctl.map_we;
            m_addr = map_wr_addr;
            m_data = map_wr_data;
            s_we   = ctl.size_we;
            s_addr = size_wr_addr;
            s_data = size_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == CLW'(CLR_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            map_mem[m_addr] <= m_data;
        end
        if (s_we)
        begin
            size_mem[s_addr] <= s_data;
        end
        map_rdata_reg  <= map_mem[map_rd_addr];
        size_rdata_reg <= size_mem[size_rd_addr];
    end

    assign map_rdata  = map_rdata_reg;
    assign size_rdata = size_rdata_reg;
    assign busy       = clearing_reg;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// First-fit block allocator: top level with the scan sequencer.
// Flow: a set-size or refused word passes from IDLE to DONE, then into the output register;
// an allocate word walks each free block in EVAL, hops each occupied block in EVAL then SKIP
// (map read, then size read) and stamps its run block by block in WRITE before DONE.
// One word in flight; the next is taken the cycle after the result is loaded.
// Reset: a clearing pass over max(NUM_BLOCKS, NUM_IDS) entries refills the map, then ready.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = 512,
    parameter int NUM_IDS    = 96
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ffba_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ffba_pkg::rsp_word_t rsp
);

    localparam int AW     = $clog2(NUM_BLOCKS);
    localparam int PW     = $clog2(NUM_BLOCKS + 1);
    localparam int IW     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int NW     = ffba_pkg::NEED_W;
    localparam int SUM_W  = ((PW > NW) ? PW : NW) + 1;
    localparam int OFW    = ((PW + ffba_pkg::GRANULE_SHIFT) > ffba_pkg::OFFSET_W) ?
                            (PW + ffba_pkg::GRANULE_SHIFT) : ffba_pkg::OFFSET_W;
    localparam logic [ffba_pkg::OWNER_W-1:0] ID_LIMIT = ffba_pkg::OWNER_W'(NUM_IDS);
    localparam logic [SUM_W-1:0]             BLK_LIMIT = SUM_W'(NUM_BLOCKS);

    // IDLE takes a word; EVAL looks at the map entry at pos; SKIP hops past an
    // occupied block using its owner's size; WRITE stamps the run; DONE hands off.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SKIP,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [PW-1:0]                start_reg, start_next;
    logic [PW-1:0]                wr_pos_reg, wr_pos_next;
    logic [NW-1:0]                need_reg, need_next;
    logic [NW-1:0]                cnt_reg, cnt_next;
    logic                         run_reg, run_next;
    logic                         owner_ok_reg, owner_ok_next;
    logic [ffba_pkg::OWNER_W-1:0] id_reg, id_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic [ffba_pkg::OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    ffba_pkg::rsp_word_t          rsp_reg, rsp_next;

    ffba_pkg::store_ctl_t         ctl;
    logic [AW-1:0]                map_rd_addr;
    logic [IW-1:0]                size_rd_addr;
    logic [ffba_pkg::OWNER_W-1:0] map_rdata;
    logic [ffba_pkg::SIZE_W-1:0]  size_rdata;
    logic                         store_busy;

    logic                         accept;
    logic [ffba_pkg::OWNER_W-1:0] req_id;
    logic                         req_id_ok;
    logic                         owner_free;
    logic [NW-1:0]                skip_raw;
    logic [NW-1:0]                skip_amt;
    logic [NW-1:0]                addend;
    logic [SUM_W-1:0]             sum;      // the shared adder
    logic [PW-1:0]                pos_inc;
    logic [NW-1:0]                cnt_new;
    logic [PW-1:0]                off_src;
    logic [OFW-1:0]               off_wide;

    ffba_store #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_IDS    (NUM_IDS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .map_rd_addr  (map_rd_addr),
        .map_wr_addr  (wr_pos_reg[AW-1:0]),
        .map_wr_data  (id_reg),
        .size_rd_addr (size_rd_addr),
        .size_wr_addr (req_id[IW-1:0]),
        .size_wr_data (req.byte_size),
        .map_rdata    (map_rdata),
        .size_rdata   (size_rdata),
        .busy         (store_busy)
    );

    assign req_ready = (state_reg == S_IDLE) && !store_busy;
    assign accept    = req_valid && req_ready;
    assign req_id    = {1'b0, req.entry_id};
    assign req_id_ok = (req_id < ID_LIMIT);

    assign owner_free = (map_rdata == ffba_pkg::FREE_OWNER);

    // hop distance past an occupied block: owner's granules, never below one;
    // owners outside the table count as size zero
    assign skip_raw = size_rdata[ffba_pkg::SIZE_W-1:ffba_pkg::GRANULE_SHIFT];
    assign skip_amt = (owner_ok_reg && (skip_raw != '0)) ? skip_raw : NW'(1);

    // EVAL uses the adder for the end-of-map test of a new run, SKIP for the hop
    assign addend  = (state_reg == S_SKIP) ? skip_amt : need_reg;
    assign sum     = SUM_W'(pos_reg) + SUM_W'(addend);
    assign pos_inc = pos_reg + 1'b1;
    assign cnt_new = run_reg ? (cnt_reg + 1'b1) : NW'(1);

    // byte offset of a run: block index times 64, kept to 15 bits
    assign off_src  = (state_reg == S_EVAL) ? pos_reg : start_reg;
    assign off_wide = OFW'(off_src) << ffba_pkg::GRANULE_SHIFT;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        wr_pos_next     = wr_pos_reg;
        need_next       = need_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        owner_ok_next   = owner_ok_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        ctl             = '0;
        map_rd_addr     = pos_reg[AW-1:0];
        size_rd_addr    = map_rdata[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_offset_next = '0;
                    if (!req_id_ok)
                    begin
                        res_status_next = ffba_pkg::ST_BAD_ID;
                        state_next      = S_DONE;
                    end
                    else if (req.operation == ffba_pkg::OP_SET_SIZE)
                    begin
                        ctl.size_we     = 1'b1;
                        res_status_next = ffba_pkg::ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        id_next     = req_id;
                        need_next   = req.byte_size[ffba_pkg::SIZE_W-1:ffba_pkg::GRANULE_SHIFT];
                        pos_next    = '0;
                        run_next    = 1'b0;
                        map_rd_addr = '0;
                        state_next  = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                if (owner_free)
                begin
                    if (!run_reg && (sum > BLK_LIMIT))
                    begin
                        // run cannot fit before the end of the map
                        res_status_next = ffba_pkg::ST_NO_RUN;
                        res_offset_next = '0;
                        state_next      = S_DONE;
                    end
                    else if (!run_reg && (need_reg == '0))
                    begin
                        // zero-size request: first free block, nothing written
                        res_status_next = ffba_pkg::ST_OK;
                        res_offset_next = off_wide[ffba_pkg::OFFSET_W-1:0];
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        if (!run_reg)
                        begin
                            start_next = pos_reg;
                        end
                        cnt_next = cnt_new;
                        if (cnt_new == need_reg)
                        begin
                            wr_pos_next = run_reg ? start_reg : pos_reg;
                            run_next    = 1'b0;
                            state_next  = S_WRITE;
                        end
                        else
                        begin
                            run_next    = 1'b1;
                            pos_next    = pos_inc;
                            map_rd_addr = pos_inc[AW-1:0];
                        end
                    end
                end
                else
                begin
                    run_next      = 1'b0;
                    owner_ok_next = (map_rdata < ID_LIMIT);
                    state_next    = S_SKIP;
                end
            end

            S_SKIP:
            begin
                if (sum >= BLK_LIMIT)
                begin
                    res_status_next = ffba_pkg::ST_NO_RUN;
                    res_offset_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next    = sum[PW-1:0];
                    map_rd_addr = sum[AW-1:0];
                    state_next  = S_EVAL;
                end
            end

            S_WRITE:
            begin
                ctl.map_we = 1'b1;
                if (wr_pos_reg == pos_reg)
                begin
                    res_status_next = ffba_pkg::ST_OK;
                    res_offset_next = off_wide[ffba_pkg::OFFSET_W-1:0];
                    state_next      = S_DONE;
                end
                else
                begin
                    wr_pos_next = wr_pos_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                // load the output register once it is empty or being drained
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_status_reg;
                    rsp_next.byte_offset = res_offset_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            run_reg       <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        start_reg      <= start_next;
        wr_pos_reg     <= wr_pos_next;
        need_reg       <= need_next;
        cnt_reg        <= cnt_next;
        owner_ok_reg   <= owner_ok_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: test/first_fit_block_allocator_test.sv
// Self-checking testbench for the first-fit block allocator.
`timescale 1ns / 1ps

module first_fit_block_allocator_test;

    localparam int NUM_BLOCKS   = 512;
    localparam int NUM_IDS      = 96;
    localparam int RANDOM_WORDS = 1000;
    localparam int STALL_LIMIT  = 20000;  // full-map hop scan plus stalls is well under this
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        ffba_pkg::req_word_t word;
        bit                  typed;   // answer below is fixed by hand
        ffba_pkg::rsp_word_t answer;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    ffba_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    ffba_pkg::rsp_word_t rsp;

    // shadow copy of the allocator state
    logic [ffba_pkg::OWNER_W-1:0] block_owner [NUM_BLOCKS];
    logic [ffba_pkg::SIZE_W-1:0]  entry_size  [NUM_IDS];

    ffba_pkg::rsp_word_t pending_grants[$];
    script_row_t         script[$];
    int unsigned         mismatches;
    int unsigned         idle_cycles;
    int unsigned         burst_left;
    int unsigned         tick;
    int unsigned         stall_mode;

    first_fit_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .NUM_IDS   (NUM_IDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_shadow();
        foreach (block_owner[i]) block_owner[i] = ffba_pkg::FREE_OWNER;
        foreach (entry_size[i]) entry_size[i] = '0;
    endfunction

    // blocks to hop past an occupied block, never less than one
    function automatic int unsigned hop_length(input logic [ffba_pkg::OWNER_W-1:0] owner);
        int unsigned n;
        n = 0;
        if (owner < NUM_IDS)
            n = entry_size[owner] >> ffba_pkg::GRANULE_SHIFT;
        return (n != 0) ? n : 1;
    endfunction

    // first-fit grant for one word; updates the shadow state
    function automatic ffba_pkg::rsp_word_t predict_grant(input ffba_pkg::req_word_t w);
        ffba_pkg::rsp_word_t r;
        int unsigned         need;
        int unsigned         pos;
        int unsigned         start;
        bit                  found;
        bit                  clear;
        r     = '0;
        found = 1'b0;
        if (w.entry_id >= NUM_IDS)
            r.status = ffba_pkg::ST_BAD_ID;
        else if (w.operation == ffba_pkg::OP_SET_SIZE)
            entry_size[w.entry_id] = w.byte_size;
        else
        begin
            need = w.byte_size >> ffba_pkg::GRANULE_SHIFT;
            pos  = 0;
            while (pos < NUM_BLOCKS)
            begin
                if (block_owner[pos] == ffba_pkg::FREE_OWNER)
                begin
                    start = pos;
                    clear = 1'b1;
                    // a run past the last block ends the whole search
                    if (start + need > NUM_BLOCKS)
                        break;
                    while (pos < start + need)
                    begin
                        if (block_owner[pos] != ffba_pkg::FREE_OWNER)
                        begin
                            clear = 1'b0;
                            break;
                        end
                        pos++;
                    end
                    if (clear)
                    begin
                        for (int unsigned i = 0; i < need; i++)
                            block_owner[start + i] = ffba_pkg::OWNER_W'(w.entry_id);
                        r.byte_offset = ffba_pkg::OFFSET_W'(start << ffba_pkg::GRANULE_SHIFT);
                        found = 1'b1;
                        break;
                    end
                end
                pos += hop_length(block_owner[pos]);
            end
            if (!found)
            begin
                r.status      = ffba_pkg::ST_NO_RUN;
                r.byte_offset = '0;
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic op, input int unsigned id, input int unsigned size,
                           input bit typed, input logic [1:0] st, input int unsigned offs);
        script_row_t row;
        row.word.operation   = op;
        row.word.entry_id    = ffba_pkg::ID_W'(id);
        row.word.byte_size   = ffba_pkg::SIZE_W'(size);
        row.typed            = typed;
        row.answer.status    = st;
        row.answer.byte_offset = ffba_pkg::OFFSET_W'(offs);
        script.push_back(row);
    endtask

    function automatic ffba_pkg::req_word_t random_word();
        ffba_pkg::req_word_t w;
        int unsigned         pick;
        int unsigned         sub;
        int unsigned         blocks;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        w.entry_id = ffba_pkg::ID_W'($urandom_range(0, NUM_IDS - 1));
        if (pick < 8)
        begin
            // refused id, either operation, any size
            w.operation = 1'($urandom_range(0, 1));
            w.entry_id  = ffba_pkg::ID_W'($urandom_range(NUM_IDS, 127));
            w.byte_size = ffba_pkg::SIZE_W'($urandom);
        end
        else if (pick < 40)
        begin
            w.operation = ffba_pkg::OP_SET_SIZE;
            if (sub < 30)
                blocks = $urandom_range(1, 16);
            else if (sub < 50)
                blocks = 0;
            else
                blocks = $urandom_range(0, 1023);
            w.byte_size = ffba_pkg::SIZE_W'((blocks << ffba_pkg::GRANULE_SHIFT)
                                            | $urandom_range(0, 63));
        end
        else
        begin
            w.operation = ffba_pkg::OP_ALLOC;
            if (sub < 30)
                blocks = 0;
            else if (sub < 80)
                blocks = $urandom_range(1, 4);
            else if (sub < 95)
                blocks = $urandom_range(5, 40);
            else
                blocks = $urandom_range(0, 1023);
            w.byte_size = ffba_pkg::SIZE_W'((blocks << ffba_pkg::GRANULE_SHIFT)
                                            | $urandom_range(0, 63));
        end
        return w;
    endfunction

    // present one word, hold it until taken, then log what should come back
    task automatic issue_word(input ffba_pkg::req_word_t w, input bit typed,
                              input ffba_pkg::rsp_word_t answer);
        ffba_pkg::rsp_word_t grant;
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        grant = predict_grant(w);
        pending_grants.push_back(typed ? answer : grant);
    endtask

    // bursts of back-to-back words with random gaps between them
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
    endtask

    // receiver stall pattern: always ready, randomly ready or a fixed duty pattern, mode re-picked at random
    initial
    begin
        rsp_ready  = 1'b0;
        tick       = 0;
        stall_mode = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 150 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ((tick % 7) < 2);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ffba_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch($sformatf("unexpected word: status %0d offset %0d",
                                          rsp.status, rsp.byte_offset));
            else
            begin
                want = pending_grants.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status: expected %0d got %0d",
                                              want.status, rsp.status));
                if (rsp.byte_offset !== want.byte_offset)
                    report_mismatch($sformatf("byte_offset: expected %0d got %0d",
                                              want.byte_offset, rsp.byte_offset));
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        clear_shadow();

        // after reset, extremes, refused ids, zero sizes and skewed hops
        add_row(ffba_pkg::OP_ALLOC,    0,   16'h0000, 1, ffba_pkg::ST_OK,     0);  // empty map
        add_row(ffba_pkg::OP_ALLOC,    96,  16'h0040, 1, ffba_pkg::ST_BAD_ID, 0);
        add_row(ffba_pkg::OP_SET_SIZE, 127, 16'hffff, 1, ffba_pkg::ST_BAD_ID, 0);
        add_row(ffba_pkg::OP_ALLOC,    1,   16'hffff, 1, ffba_pkg::ST_NO_RUN, 0);  // far past end
        add_row(ffba_pkg::OP_ALLOC,    2,   16'h8040, 1, ffba_pkg::ST_NO_RUN, 0);  // one too many
        add_row(ffba_pkg::OP_SET_SIZE, 95,  16'h00c0, 1, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    95,  16'h00ff, 1, ffba_pkg::ST_OK,     0);  // low bits off
        add_row(ffba_pkg::OP_ALLOC,    10,  16'h003f, 0, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_SET_SIZE, 10,  16'h0000, 1, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    10,  16'h0080, 0, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    11,  16'h0040, 0, ffba_pkg::ST_OK,     0);  // hop of one
        add_row(ffba_pkg::OP_SET_SIZE, 95,  16'h0040, 1, ffba_pkg::ST_OK,     0);  // smaller
        add_row(ffba_pkg::OP_SET_SIZE, 10,  16'h1000, 1, ffba_pkg::ST_OK,     0);  // jumps free
        add_row(ffba_pkg::OP_ALLOC,    12,  16'h0040, 0, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    0,   16'h0000, 0, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    63,  16'h2000, 0, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_SET_SIZE, 0,   16'hffff, 1, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_SET_SIZE, 64,  16'h5555, 1, ffba_pkg::ST_OK,     0);
        add_row(ffba_pkg::OP_ALLOC,    64,  16'haaaa, 1, ffba_pkg::ST_NO_RUN, 0);
        add_row(ffba_pkg::OP_ALLOC,    127, 16'h0000, 1, ffba_pkg::ST_BAD_ID, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            issue_word(script[i].word, script[i].typed, script[i].answer);
            pace_sender();
        end

        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            // hold off once midway until everything has come back
            if (n == RANDOM_WORDS / 2)
                wait_for_drain();
            issue_word(random_word(), 1'b0, '0);
            pace_sender();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ffba_pkg.sv
rtl/ffba_store.sv
rtl/first_fit_block_allocator.sv
test/first_fit_block_allocator_test.sv
